// ===== src/ascii_range_line_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII range line parser
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASCII_RANGE_LINE_PARSER_ASSERT_SVH
`define ASCII_RANGE_LINE_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define ARLP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("arlp: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ARLP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arlp: assertion failed");

`else

`define ARLP_ASSERT(name, clk, rst_n, prop)
`define ARLP_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/arlp_pkg.sv =====
// ----------------------------------------------------------------------------
// arlp_pkg
// Shared constants and types of the ASCII range line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package arlp_pkg;

  // A byte that arrives while more than this many characters are held
  // drops the line first.
  localparam int LINE_LIMIT = 30;
  localparam int KEPT_W     = $clog2(LINE_LIMIT + 2);
  localparam int VALUE_W    = 16;
  localparam int PROD_W     = VALUE_W + 4;

  localparam logic [KEPT_W-1:0]  KEPT_LIMIT     = KEPT_W'(LINE_LIMIT);
  localparam logic [1:0]         NUMBERS_NEEDED = 2'd3;
  localparam logic [VALUE_W-1:0] VALUE_MAX      = {VALUE_W{1'b1}};

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [KEPT_W-1:0]  kept_count;
    logic [1:0]         numbers_seen;
    logic               inside_number;
    logic [VALUE_W-1:0] first_value;
  } line_state_t;

  typedef struct packed {
    logic               emit;
    logic [VALUE_W-1:0] range_hundredths;
    logic               line_ok;
  } line_result_t;

endpackage

`default_nettype wire

// ===== src/arlp_line_step.sv =====
// ----------------------------------------------------------------------------
// arlp_line_step
// Next-state and result logic for one received byte of a line.
// ----------------------------------------------------------------------------
`default_nettype none

module arlp_line_step (
  input  arlp_pkg::line_state_t  state_i,
  input  logic [7:0]             rx_byte_i,
  output arlp_pkg::line_state_t  state_o,
  output arlp_pkg::line_result_t result_o
);
  import arlp_pkg::*;

  logic               is_nl;
  logic               is_digit;
  logic               is_space;
  logic               line_ok;
  logic [3:0]         digit;
  logic [PROD_W-1:0]  value_ext;
  logic [PROD_W-1:0]  value_x10;
  line_state_t        base;
  line_state_t        nxt;

  assign is_nl    = (rx_byte_i == CHAR_NL);
  assign is_digit = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
  assign is_space = (rx_byte_i == CHAR_SPACE);
  assign digit    = 4'(rx_byte_i - CHAR_ZERO);

  assign line_ok = (state_i.numbers_seen == NUMBERS_NEEDED);

  // Ten times the value plus the new digit, as two shifts and adds.
  assign value_ext = PROD_W'(base.first_value);
  assign value_x10 = (value_ext << 3) + (value_ext << 1) + PROD_W'(digit);

  always_comb begin
    if (is_nl || (state_i.kept_count > KEPT_LIMIT)) begin
      base = '0;
    end else begin
      base = state_i;
    end
  end

  always_comb begin
    nxt = base;
    if (is_digit) begin
      nxt.inside_number = 1'b1;
      if (!base.inside_number && (base.numbers_seen != NUMBERS_NEEDED)) begin
        nxt.numbers_seen = base.numbers_seen + 2'd1;
      end
      if (nxt.numbers_seen == 2'd1) begin
        if (value_x10 > PROD_W'(VALUE_MAX)) begin
          nxt.first_value = VALUE_MAX;
        end else begin
          nxt.first_value = value_x10[VALUE_W-1:0];
        end
      end
      nxt.kept_count = base.kept_count + KEPT_W'(1);
    end else if (is_space) begin
      nxt.inside_number = 1'b0;
      nxt.kept_count    = base.kept_count + KEPT_W'(1);
    end
  end

  // A newline that ends a non-empty line, even an overlong one, gives a result.
  always_comb begin
    result_o.emit             = is_nl && (state_i.kept_count != '0);
    result_o.line_ok          = line_ok;
    result_o.range_hundredths = line_ok ? state_i.first_value : '0;
    if (result_o.emit) begin
      state_o = '0;
    end else begin
      state_o = nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/ascii_range_line_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_range_line_parser
// Builds lines from received bytes and reports the first number of each
// complete line that held at least three numbers (zero otherwise) with a flag for such lines.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  rx       in         rx_valid_i/rx_ready_o   rx_byte_i[7:0]
//  res      out        res_valid_o/res_ready_i range_hundredths_o[15:0], line_ok_o
//
//  One item per cycle is accepted unless a newline waits on a full result
//  slot; a byte is first held in the input register, then updates the line
//  state and the result register, from which a result is offered.
//  Reset clears the line state and empties both stages.
//  A stalled result holds only bytes that end a line: other bytes pass the
//  second stage while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascii_range_line_parser_assert.svh"

module ascii_range_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [15:0] range_hundredths_o,
  output logic        line_ok_o
);
  import arlp_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  line_state_t  state_q;
  line_state_t  state_d;
  line_result_t step_res;
  logic         stage_adv;
  logic         res_valid_q;
  logic [VALUE_W-1:0] range_q;
  logic         ok_q;

  arlp_line_step u_step (
    .state_i   (state_q),
    .rx_byte_i (in_byte_q),
    .state_o   (state_d),
    .result_o  (step_res)
  );

  // The stored byte moves on unless it ends a line and the result slot is full and not being read.
  assign stage_adv  = in_valid_q && (!step_res.emit || !res_valid_q || res_ready_i);
  assign rx_ready_o = !in_valid_q || stage_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (rx_ready_o) begin
        in_valid_q <= rx_valid_i;
      end
      if (stage_adv) begin
        state_q <= state_d;
      end
      if (stage_adv && step_res.emit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
    if (stage_adv && step_res.emit) begin
      range_q <= step_res.range_hundredths;
      ok_q    <= step_res.line_ok;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign range_hundredths_o = range_q;
  assign line_ok_o          = ok_q;

  `ARLP_ASSERT(a_kept_bound, clk_i, rst_ni, state_q.kept_count <= (KEPT_LIMIT + KEPT_W'(1)))
  `ARLP_ASSERT(a_bad_line_zero, clk_i, rst_ni, !res_valid_o || line_ok_o || (range_hundredths_o == '0))
  `ARLP_ASSERT(a_no_number_no_value, clk_i, rst_ni, (state_q.numbers_seen != '0) || (state_q.first_value == '0))
  `ARLP_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, stage_adv && step_res.emit, res_valid_o)
  `ARLP_ASSERT_NEXT(a_emit_clears, clk_i, rst_ni, stage_adv && step_res.emit, state_q == '0)

endmodule

`default_nettype wire
